FILE: rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: rtl/cssg_pkg.sv
// shared types and constants of the shape span generator
`default_nettype none

package cssg_pkg;

	localparam int MAX_DIM_DEF = 1024;

	// fixed field widths
	localparam int ACT_W   = 2;
	localparam int ORG_W   = 12;
	localparam int RECT_W  = 11;
	localparam int RAD_W   = 10;
	localparam int ROW_W   = 10;
	localparam int COLOR_W = 32;
	localparam int CFG_W   = 11;
	localparam int START_W = 10;
	localparam int LEN_W   = 11;
	localparam int ADDR_W  = 20;

	// signed coordinate width covering every edge sum
	localparam int CRD_W   = 14;
	// square root result bits and the bit counter
	localparam int ROOT_W  = 12;
	localparam int ROOT_BW = 4;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

	localparam logic [ACT_W-1:0] ACT_CANVAS = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RECT   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CIRCLE = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] cw;
		logic [CFG_W-1:0] ch;
	} cssg_cfg_t;

	typedef struct packed {
		logic               valid;
		logic               span_valid;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} cssg_res_t;

endpackage

`default_nettype wire

FILE: rtl/cssg_mul.sv
// shared unsigned multiplier used for every product of the core
`default_nettype none

module cssg_mul #(
	parameter int W = 13
) (
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic      [2*W-1:0] p
);

	assign p = (2*W)'(a) * (2*W)'(b);

endmodule

`default_nettype wire

FILE: rtl/cssg_core.sv
// sequencer and datapath: square terms, bitwise square root, clipping, address
`default_nettype none

module cssg_core #(
	parameter int MAX_DIM = cssg_pkg::MAX_DIM_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cssg_pkg::cssg_cfg_t                cfg,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [cssg_pkg::ACT_W-1:0]         action,
	input  wire logic signed [cssg_pkg::ORG_W-1:0]  origin_x,
	input  wire logic signed [cssg_pkg::ORG_W-1:0]  origin_y,
	input  wire logic [cssg_pkg::RECT_W-1:0]        rect_w,
	input  wire logic [cssg_pkg::RECT_W-1:0]        rect_h,
	input  wire logic [cssg_pkg::RAD_W-1:0]         radius,
	input  wire logic [cssg_pkg::ROW_W-1:0]         row,
	input  wire logic [cssg_pkg::COLOR_W-1:0]       paint,
	input  wire logic                               out_free,
	output cssg_pkg::cssg_res_t                     res
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int MUL_W = (DIM_W > cssg_pkg::ROOT_W) ? DIM_W : cssg_pkg::ROOT_W;
	localparam int CRD_W = cssg_pkg::CRD_W;
	localparam int RAD_W = cssg_pkg::RAD_W;
	localparam int ROOT_W = cssg_pkg::ROOT_W;
	localparam int UCRD_W = CRD_W - 1;
	// signed one keeps the coordinate compares signed
	localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RSQ,
		S_DYSQ,
		S_ROOT,
		S_CLIP,
		S_ADDR
	} state_t;

	state_t state_q;

	logic [cssg_pkg::ACT_W-1:0]        act_q;
	logic signed [cssg_pkg::ORG_W-1:0] ox_q;
	logic signed [cssg_pkg::ORG_W-1:0] oy_q;
	logic [cssg_pkg::RECT_W-1:0]       rw_q;
	logic [cssg_pkg::RECT_W-1:0]       rh_q;
	logic [RAD_W-1:0]                  r_q;
	logic [cssg_pkg::ROW_W-1:0]        y_q;
	logic [cssg_pkg::COLOR_W-1:0]      color_q;
	logic [DIM_W-1:0]                  w_q;
	logic [DIM_W-1:0]                  h_q;
	logic [2*RAD_W-1:0]                rsq_q;
	logic [2*RAD_W-1:0]                rem_q;
	logic [ROOT_W-1:0]                 root_q;
	logic [cssg_pkg::ROOT_BW-1:0]      bit_q;
	logic                              hit_q;
	logic [UCRD_W-1:0]                 start_q;
	logic [UCRD_W-1:0]                 len_q;

	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [2*MUL_W-1:0] mul_p;

	logic signed [CRD_W-1:0] ox_s, oy_s, y_s, r_s, rw_s, rh_s, w_s, h_s, root_s;
	logic signed [CRD_W-1:0] dy_s, dy_abs;
	logic signed [CRD_W-1:0] lo, hi, lo_c, hi_c, hi_r;
	logic                    in_box, dims_ok, hit;
	logic [ROOT_W-1:0]       cand;
	logic [cssg_pkg::ADDR_W-1:0] addr;

	assign ox_s   = CRD_W'(ox_q);
	assign oy_s   = CRD_W'(oy_q);
	assign y_s    = signed'(CRD_W'(y_q));
	assign r_s    = signed'(CRD_W'(r_q));
	assign rw_s   = signed'(CRD_W'(rw_q));
	assign rh_s   = signed'(CRD_W'(rh_q));
	assign w_s    = signed'(CRD_W'(w_q));
	assign h_s    = signed'(CRD_W'(h_q));
	assign root_s = signed'(CRD_W'(root_q));

	assign dy_s   = y_s - oy_s;
	assign dy_abs = dy_s[CRD_W-1] ? -dy_s : dy_s;
	// circle bounding box is [c-r, c+r-1]
	assign in_box = (y_s >= oy_s - r_s) && (y_s <= oy_s + r_s - CRD_ONE);
	assign cand   = root_q | (ROOT_W'(1) << bit_q);

	always_comb begin
		unique case (state_q)
			S_RSQ: begin
				mul_a = MUL_W'(r_q);
				mul_b = MUL_W'(r_q);
			end
			S_DYSQ: begin
				mul_a = MUL_W'(dy_abs[RAD_W-1:0]);
				mul_b = MUL_W'(dy_abs[RAD_W-1:0]);
			end
			S_ROOT: begin
				mul_a = MUL_W'(cand);
				mul_b = MUL_W'(cand);
			end
			S_ADDR: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(w_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cssg_mul #(.W(MUL_W)) u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	// run edges per shape, then clip to the canvas
	always_comb begin
		dims_ok = (w_q != '0) && (h_q != '0) && (y_s < h_s);
		lo      = '0;
		hi      = '0;
		hit     = 1'b0;
		hi_r    = ox_s + root_s;
		unique case (act_q)
			cssg_pkg::ACT_CANVAS: begin
				lo  = '0;
				hi  = w_s - CRD_ONE;
				hit = 1'b1;
			end
			cssg_pkg::ACT_RECT: begin
				lo  = ox_s;
				hi  = ox_s + rw_s - CRD_ONE;
				hit = (y_s >= oy_s) && (y_s <= oy_s + rh_s - CRD_ONE);
			end
			cssg_pkg::ACT_CIRCLE: begin
				lo  = ox_s - root_s;
				hi  = (hi_r > ox_s + r_s - CRD_ONE) ? ox_s + r_s - CRD_ONE : hi_r;
				hit = in_box;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
		lo_c = lo[CRD_W-1] ? '0 : lo;
		hi_c = (hi > w_s - CRD_ONE) ? w_s - CRD_ONE : hi;
		hit  = hit && dims_ok && (hi_c >= lo_c);
	end

	assign addr     = cssg_pkg::ADDR_W'(mul_p) + cssg_pkg::ADDR_W'(start_q);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res.valid <= 1'b0;
		end else begin
			res.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q   <= action;
						ox_q    <= origin_x;
						oy_q    <= origin_y;
						rw_q    <= rect_w;
						rh_q    <= rect_h;
						r_q     <= radius;
						y_q     <= row;
						color_q <= paint;
						w_q     <= (32'(cfg.cw) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
							: DIM_W'(cfg.cw);
						h_q     <= (32'(cfg.ch) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
							: DIM_W'(cfg.ch);
						state_q <= S_RSQ;
					end
				end
				S_RSQ: begin
					rsq_q <= mul_p[2*RAD_W-1:0];
					if (act_q == cssg_pkg::ACT_CIRCLE && in_box) begin
						state_q <= S_DYSQ;
					end else begin
						root_q  <= '0;
						state_q <= S_CLIP;
					end
				end
				S_DYSQ: begin
					rem_q   <= rsq_q - mul_p[2*RAD_W-1:0];
					root_q  <= '0;
					bit_q   <= cssg_pkg::ROOT_BW'(ROOT_W - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					// keep the trial bit when its square still fits
					if (mul_p[2*ROOT_W-1:0] <= (2*ROOT_W)'(rem_q)) begin
						root_q <= cand;
					end
					if (bit_q == '0) begin
						state_q <= S_CLIP;
					end else begin
						bit_q <= bit_q - cssg_pkg::ROOT_BW'(1);
					end
				end
				S_CLIP: begin
					hit_q   <= hit;
					start_q <= lo_c[UCRD_W-1:0];
					len_q   <= UCRD_W'(hi_c - lo_c + CRD_ONE);
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					if (out_free) begin
						res.valid <= 1'b1;
						if (hit_q) begin
							res.span_valid <= 1'b1;
							res.start      <= start_q[cssg_pkg::START_W-1:0];
							res.length     <= len_q[cssg_pkg::LEN_W-1:0];
							res.addr       <= addr;
							res.color      <= color_q;
						end else begin
							res.span_valid <= 1'b0;
							res.start      <= '0;
							res.length     <= '0;
							res.addr       <= '0;
							res.color      <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/clipped_shape_span_generator_unit.sv
// Clipped shape span generator: one painted run per requested canvas row.
// Input channel in_valid/in_ready carries one shape word: action, origin,
// rectangle size or radius, the row and the paint color. Output channel
// out_valid/out_ready carries one span word per input word: span_valid,
// start column, length, linear pixel address and color; an empty run
// shows span_valid low with every other field zero.
// Canvas width and height are set through cfg_we/cfg_index/cfg_data, by the
// user only while no word is in flight; the block does not enforce it.
// Sizes above MAX_DIM count as MAX_DIM; one shared multiplier does every
// product under a small sequencer. From accept to out_valid a word passes
// the states RSQ, CLIP and ADDR and then the output register for canvas,
// rectangle and rows outside a circle's box; a row inside a circle also
// passes DYSQ and ROOT, the bit-by-bit square root of the half-width.
// in_ready is low while a word is at work, so no new word is taken.
// The output register holds a finished word while the receiver stalls,
// and the next input word is taken meanwhile; its result waits in the
// sequencer until the register frees up.
// Reset clears the sequencer and output valid and loads width 640 and
// height 480.
`default_nettype none

module clipped_shape_span_generator_unit #(
	parameter int MAX_DIM = cssg_pkg::MAX_DIM_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cssg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cssg_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [cssg_pkg::ACT_W-1:0]          action,
	input  wire logic signed [cssg_pkg::ORG_W-1:0]   origin_x,
	input  wire logic signed [cssg_pkg::ORG_W-1:0]   origin_y,
	input  wire logic [cssg_pkg::RECT_W-1:0]         rect_w,
	input  wire logic [cssg_pkg::RECT_W-1:0]         rect_h,
	input  wire logic [cssg_pkg::RAD_W-1:0]          radius,
	input  wire logic [cssg_pkg::ROW_W-1:0]          row,
	input  wire logic [cssg_pkg::COLOR_W-1:0]        paint,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     span_valid,
	output logic [cssg_pkg::START_W-1:0]             span_start,
	output logic [cssg_pkg::LEN_W-1:0]               span_length,
	output logic [cssg_pkg::ADDR_W-1:0]              pixel_address,
	output logic [cssg_pkg::COLOR_W-1:0]             span_color
);

	cssg_pkg::cssg_cfg_t cfg_q;
	cssg_pkg::cssg_res_t res;
	logic                out_valid_q;
	logic                out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cw <= cssg_pkg::WIDTH_RST;
			cfg_q.ch <= cssg_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cssg_pkg::CFG_WIDTH:  cfg_q.cw <= cfg_data;
				cssg_pkg::CFG_HEIGHT: cfg_q.ch <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	cssg_core #(.MAX_DIM(MAX_DIM)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.rect_w   (rect_w),
		.rect_h   (rect_h),
		.radius   (radius),
		.row      (row),
		.paint    (paint),
		.out_free (out_free),
		.res      (res)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			span_valid    <= res.span_valid;
			span_start    <= res.start;
			span_length   <= res.length;
			pixel_address <= res.addr;
			span_color    <= res.color;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/cssg_checker.sv
// port-level checker for the span generator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module cssg_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          span_valid,
	input wire logic [cssg_pkg::START_W-1:0]  span_start,
	input wire logic [cssg_pkg::LEN_W-1:0]    span_length,
	input wire logic [cssg_pkg::ADDR_W-1:0]   pixel_address,
	input wire logic [cssg_pkg::COLOR_W-1:0]  span_color
);

	// an empty run carries all-zero fields
	`ASSERT_IMPL(a_empty_zero, clk, arst_n, out_valid && !span_valid, span_start == '0 && span_length == '0 && pixel_address == '0 && span_color == '0)

	// a painted run is never zero long
	`ASSERT_IMPL(a_len_nonzero, clk, arst_n, out_valid && span_valid, span_length != '0)

	// the block is busy right after it takes a word
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled result word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_address) && $stable(span_color))

endmodule

bind clipped_shape_span_generator_unit cssg_checker u_cssg_checker (.*);

`default_nettype wire

FILE: tb/sv/cssg_span_check_pkg.sv
// span prediction and scoreboard for the shape span generator testbench
package cssg_span_check_pkg;
	import cssg_pkg::*;

	// action code that names no shape
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0]          action;
		logic signed [ORG_W-1:0]   origin_x;
		logic signed [ORG_W-1:0]   origin_y;
		logic [RECT_W-1:0]         rect_w;
		logic [RECT_W-1:0]         rect_h;
		logic [RAD_W-1:0]          radius;
		logic [ROW_W-1:0]          row;
		logic [COLOR_W-1:0]        paint;
	} shape_word_t;

	typedef struct packed {
		logic               span_valid;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} span_word_t;

	class span_scoreboard;
		logic [CFG_W-1:0] canvas_w;
		logic [CFG_W-1:0] canvas_h;
		span_word_t expected_spans[$];
		int errors;

		function new();
			canvas_w = WIDTH_RST;
			canvas_h = HEIGHT_RST;
			errors = 0;
		endfunction

		function void set_canvas(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			if (idx == CFG_WIDTH) begin
				canvas_w = value;
			end else if (idx == CFG_HEIGHT) begin
				canvas_h = value;
			end
		endfunction

		function int pending();
			return expected_spans.size();
		endfunction

		// restoring square root, one result bit per pass
		function int unsigned floor_root(int unsigned v);
			int unsigned root;
			int unsigned cand;
			root = 0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				cand = root | (32'd1 << b);
				if (cand * cand <= v) root = cand;
			end
			return root;
		endfunction

		function span_word_t predict_span(shape_word_t s);
			span_word_t span;
			int cols, lines, ox, oy, y, r, dy, lo, hi, half;
			bit hit;
			cols = (canvas_w > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(canvas_w);
			lines = (canvas_h > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(canvas_h);
			ox = $signed(s.origin_x);
			oy = $signed(s.origin_y);
			y = int'(s.row);
			r = int'(s.radius);
			lo = 0;
			hi = -1;
			hit = 1'b0;
			if (cols > 0 && lines > 0 && y < lines) begin
				case (s.action)
				ACT_CANVAS: begin
					lo = 0;
					hi = cols - 1;
					hit = 1'b1;
				end
				ACT_RECT: begin
					if (y >= oy && y <= oy + int'(s.rect_h) - 1) begin
						lo = ox;
						hi = ox + int'(s.rect_w) - 1;
						hit = 1'b1;
					end
				end
				ACT_CIRCLE: begin
					// box rows run from center-r to center+r-1
					if (y >= oy - r && y <= oy + r - 1) begin
						dy = y - oy;
						half = int'(floor_root(r * r - dy * dy));
						lo = ox - half;
						hi = ox + half;
						if (hi > ox + r - 1) hi = ox + r - 1;
						hit = 1'b1;
					end
				end
				default: ;
				endcase
			end
			if (hit) begin
				if (lo < 0) lo = 0;
				if (hi > cols - 1) hi = cols - 1;
				hit = (hi >= lo);
			end
			span = '0;
			if (hit) begin
				span.span_valid = 1'b1;
				span.start = START_W'(lo);
				span.length = LEN_W'(hi - lo + 1);
				span.addr = ADDR_W'(y * cols + lo);
				span.color = s.paint;
			end
			return span;
		endfunction

		function void note_shape(shape_word_t s);
			expected_spans.push_back(predict_span(s));
		endfunction

		task report(string msg);
			if (errors < 100) $display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
			end
		endtask

		task check_span(span_word_t got);
			span_word_t want;
			if (expected_spans.size() == 0) begin
				report("span word arrived with no shape word outstanding");
				return;
			end
			want = expected_spans.pop_front();
			compare_field("span_valid", 32'(got.span_valid), 32'(want.span_valid));
			compare_field("span_start", 32'(got.start), 32'(want.start));
			compare_field("span_length", 32'(got.length), 32'(want.length));
			compare_field("pixel_address", 32'(got.addr), 32'(want.addr));
			compare_field("span_color", got.color, want.color);
		endtask
	endclass

endpackage

FILE: tb/sv/clipped_shape_span_generator_unit_test.sv
// top-level testbench of the clipped shape span generator
module clipped_shape_span_generator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cssg_pkg::*;
	import cssg_span_check_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASES = 10;
	localparam int WORDS_PER_PHASE = 135;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [ACT_W-1:0]         action = ACT_CANVAS;
	logic signed [ORG_W-1:0]  origin_x = '0;
	logic signed [ORG_W-1:0]  origin_y = '0;
	logic [RECT_W-1:0]        rect_w = '0;
	logic [RECT_W-1:0]        rect_h = '0;
	logic [RAD_W-1:0]         radius = '0;
	logic [ROW_W-1:0]         row = '0;
	logic [COLOR_W-1:0]       paint = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     span_valid;
	logic [START_W-1:0]       span_start;
	logic [LEN_W-1:0]         span_length;
	logic [ADDR_W-1:0]        pixel_address;
	logic [COLOR_W-1:0]       span_color;

	// both sides run without gaps while set
	bit steady = 1'b0;

	span_scoreboard board = new();

	always #2 clk = ~clk;

	clipped_shape_span_generator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.radius(radius),
		.row(row),
		.paint(paint),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.span_valid(span_valid),
		.span_start(span_start),
		.span_length(span_length),
		.pixel_address(pixel_address),
		.span_color(span_color)
	);

	function automatic shape_word_t shape_of(logic [ACT_W-1:0] a, int ox, int oy, int rw,
			int rh, int r, int y, logic [COLOR_W-1:0] c);
		shape_word_t s;
		s.action = a;
		s.origin_x = ORG_W'(ox);
		s.origin_y = ORG_W'(oy);
		s.rect_w = RECT_W'(rw);
		s.rect_h = RECT_W'(rh);
		s.radius = RAD_W'(r);
		s.row = ROW_W'(y);
		s.paint = c;
		return s;
	endfunction

	// mostly shapes that land on the requested row, some with raw fields
	function automatic shape_word_t random_shape(int cols, int lines);
		shape_word_t s;
		int kind, rad, span_cols;
		span_cols = (cols > 0) ? cols : 1;
		s.origin_x = ORG_W'($urandom);
		s.origin_y = ORG_W'($urandom);
		s.rect_w = RECT_W'($urandom);
		s.rect_h = RECT_W'($urandom);
		s.radius = RAD_W'($urandom);
		s.row = ROW_W'($urandom);
		s.paint = $urandom;
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			s.action = ACT_CANVAS;
		end else if (kind == 2) begin
			s.action = ACT_NONE;
		end else if (kind < 11) begin
			s.action = ACT_RECT;
		end else begin
			s.action = ACT_CIRCLE;
		end
		if ($urandom_range(0, 7) == 0) return s;
		if (lines > 0 && $urandom_range(0, 7) != 0) s.row = ROW_W'($urandom_range(0, lines - 1));
		if (s.action == ACT_RECT) begin
			if ($urandom_range(0, 3) != 0) s.rect_w = RECT_W'($urandom_range(0, span_cols + 16));
			if ($urandom_range(0, 3) != 0) s.rect_h = RECT_W'($urandom_range(0, 64));
			s.origin_x = ORG_W'(int'($urandom_range(0, span_cols + 64)) - 32
				- int'($urandom_range(0, s.rect_w)));
			s.origin_y = ORG_W'(int'(s.row) - int'($urandom_range(0, s.rect_h))
				+ int'($urandom_range(0, 2)) - 1);
		end else if (s.action == ACT_CIRCLE) begin
			if ($urandom_range(0, 4) != 0) s.radius = RAD_W'($urandom_range(0, 40));
			rad = int'(s.radius);
			s.origin_y = ORG_W'(int'(s.row) - rad + int'($urandom_range(0, 2 * rad + 1)));
			s.origin_x = ORG_W'(int'($urandom_range(0, span_cols + 2 * rad)) - rad);
		end
		return s;
	endfunction

	task automatic send_shape(shape_word_t s);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		action <= s.action;
		origin_x <= s.origin_x;
		origin_y <= s.origin_y;
		rect_w <= s.rect_w;
		rect_h <= s.rect_h;
		radius <= s.radius;
		row <= s.row;
		paint <= s.paint;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_shape(s);
	endtask

	task automatic write_canvas(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk) cfg_we <= 1'b0;
		board.set_canvas(idx, value);
	endtask

	// wait for every outstanding span word, then let the block settle
	task automatic drain_spans();
		@(negedge clk) in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : span_sink
		int stall;
		span_word_t got;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			repeat (stall) @(negedge clk) out_ready <= 1'b0;
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.span_valid = span_valid;
			got.start = span_start;
			got.length = span_length;
			got.addr = pixel_address;
			got.color = span_color;
			board.check_span(got);
		end
	end

	initial begin : watchdog
		int idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int phase_w [PHASES] = '{1024, 1, 0, 640, 2047, 1000, 17, 1025, 0, 0};
		int phase_h [PHASES] = '{1024, 1, 480, 0, 2047, 3, 1024, 1100, 0, 0};
		int cols, lines;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed words on the reset canvas of 640 by 480
		send_shape(shape_of(ACT_CANVAS, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_shape(shape_of(ACT_CANVAS, 2047, -2048, 2047, 2047, 1023, 479, 32'h0));
		send_shape(shape_of(ACT_CANVAS, 0, 0, 0, 0, 0, 480, 32'h1234_5678));
		send_shape(shape_of(ACT_CANVAS, 0, 0, 0, 0, 0, 1023, 32'h8765_4321));
		send_shape(shape_of(ACT_NONE, 0, 0, 100, 100, 100, 10, 32'hDEAD_BEEF));
		// rectangles: zero-sized, clipped, off-canvas and full-row
		send_shape(shape_of(ACT_RECT, 10, 0, 0, 5, 0, 1, 32'hA5A5_A5A5));
		send_shape(shape_of(ACT_RECT, 10, 0, 5, 0, 0, 0, 32'h5A5A_5A5A));
		send_shape(shape_of(ACT_RECT, -2048, -2048, 2047, 2047, 0, 5, 32'h0F0F_0F0F));
		send_shape(shape_of(ACT_RECT, -10, 0, 30, 10, 0, 3, 32'hF0F0_F0F0));
		send_shape(shape_of(ACT_RECT, 630, 100, 2047, 1, 0, 100, 32'h00FF_00FF));
		send_shape(shape_of(ACT_RECT, 2047, 2047, 2047, 2047, 0, 100, 32'hFF00_FF00));
		send_shape(shape_of(ACT_RECT, 0, 479, 640, 1, 0, 479, 32'h1111_1111));
		send_shape(shape_of(ACT_RECT, 0, 0, 2047, 2047, 0, 1023, 32'h2222_2222));
		// circles: zero radius, huge radius, top and bottom box rows, clipping
		send_shape(shape_of(ACT_CIRCLE, 320, 240, 0, 0, 0, 240, 32'h3333_3333));
		send_shape(shape_of(ACT_CIRCLE, 320, 240, 0, 0, 1023, 240, 32'h4444_4444));
		send_shape(shape_of(ACT_CIRCLE, 100, 200, 0, 0, 50, 150, 32'h5555_5555));
		send_shape(shape_of(ACT_CIRCLE, 100, 200, 0, 0, 50, 249, 32'h6666_6666));
		send_shape(shape_of(ACT_CIRCLE, 100, 200, 0, 0, 50, 250, 32'h7777_7777));
		send_shape(shape_of(ACT_CIRCLE, 5, 60, 0, 0, 30, 60, 32'h8888_8888));
		send_shape(shape_of(ACT_CIRCLE, -2048, 0, 0, 0, 1023, 0, 32'h9999_9999));
		send_shape(shape_of(ACT_CIRCLE, 2047, 2047, 0, 0, 1023, 1023, 32'hAAAA_AAAA));
		send_shape(shape_of(ACT_CIRCLE, 639, 479, 0, 0, 1, 478, 32'hBBBB_BBBB));
		send_shape(shape_of(ACT_CIRCLE, 0, 0, 0, 0, 1, 0, 32'hCCCC_CCCC));

		for (int p = 0; p < PHASES; p++) begin
			if (phase_w[p] == 0 && p >= PHASES - 2) phase_w[p] = $urandom_range(1, 1024);
			if (phase_h[p] == 0 && p >= PHASES - 2) phase_h[p] = $urandom_range(1, 1024);
			drain_spans();
			write_canvas(CFG_WIDTH, CFG_W'(phase_w[p]));
			write_canvas(CFG_HEIGHT, CFG_W'(phase_h[p]));
			cols = (phase_w[p] > MAX_DIM_DEF) ? MAX_DIM_DEF : phase_w[p];
			lines = (phase_h[p] > MAX_DIM_DEF) ? MAX_DIM_DEF : phase_h[p];
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if ($urandom_range(0, 39) == 0) steady = !steady;
				send_shape(random_shape(cols, lines));
			end
		end
		drain_spans();

		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
